// ===== design/pbwa_pkg.sv =====
`default_nettype none

package pbwa_pkg;

  localparam logic [63:0] UPPER_ONES  = 64'hffff_ffff_0000_0000;
  localparam logic [63:0] EMPTY_BASE  = 64'd1;
  localparam logic [63:0] EMPTY_LIMIT = 64'd0;

  // BAR type field, bits 2:1 of a memory BAR.
  localparam logic [1:0] MEM_TYPE_64 = 2'b10;

  localparam logic [31:0] IO_ADDR_MASK  = ~32'd3;
  localparam logic [31:0] MEM_ADDR_MASK = ~32'd15;

  localparam logic KIND_CLEAR = 1'b0;

  localparam logic [1:0] REGION_NONE    = 2'd0;
  localparam logic [1:0] REGION_IO      = 2'd1;
  localparam logic [1:0] REGION_MEM_LOW = 2'd2;
  localparam logic [1:0] REGION_MEM_HI  = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] bar_low;
    logic [31:0] bar_high;
    logic [31:0] mask_low;
    logic [31:0] mask_high;
  } in_t;

  typedef struct packed {
    logic [63:0] bar_base;
    logic [63:0] bar_length;
    logic [1:0]  region;
    logic        uses_next_slot;
    logic [63:0] io_window_base;
    logic [63:0] io_window_limit;
    logic [63:0] low_mem_window_base;
    logic [63:0] low_mem_window_limit;
    logic [63:0] high_mem_window_base;
    logic [63:0] high_mem_window_limit;
  } out_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } win_t;

  localparam win_t EMPTY_WIN = '{lo: EMPTY_BASE, hi: EMPTY_LIMIT};

endpackage

`default_nettype wire

// ===== design/pci_bar_window_accumulator.sv =====
// Decodes one sized PCI BAR per transfer and folds its range into one of three
// address windows (I/O, memory below 4 GiB, memory at or above 4 GiB). Each
// input transfer yields exactly one result transfer carrying the decode and the
// windows as they stand after that item; a clear item empties all windows.
// The block takes one item per cycle while the result is not stalled: an input
// register feeds a single 64-bit end-address add plus min/max compares per
// window, and the result lands in an output register, so each result passes
// through the input register and then the output register before its own
// transfer. A stalled result holds the output register; the input register
// still takes an item while it is empty.
`default_nettype none

module pci_bar_window_accumulator (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire pbwa_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output pbwa_pkg::out_t      out_data_o
);

  function automatic pbwa_pkg::win_t widen_win(pbwa_pkg::win_t w, logic [63:0] base,
                                               logic [63:0] last);
    pbwa_pkg::win_t r;
    r = w;
    if (w.lo > w.hi) begin
      r.lo = base;
      r.hi = last;
    end else begin
      if (base < w.lo) r.lo = base;
      if (last > w.hi) r.hi = last;
    end
    return r;
  endfunction

  logic           in_valid_q;
  pbwa_pkg::in_t  in_q;
  logic           out_valid_q;
  pbwa_pkg::out_t out_q, out_d;
  pbwa_pkg::win_t io_win_q, io_win_d;
  pbwa_pkg::win_t lm_win_q, lm_win_d;
  pbwa_pkg::win_t hm_win_q, hm_win_d;

  logic        advance;
  logic        is_io, is_wide, range_ok;
  logic [63:0] base, smask, len;
  logic [64:0] last_sum;
  logic [1:0]  sel;

  // The output register moves whenever it is empty or its transfer completes.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_comb begin
    is_io   = in_q.bar_low[0];
    is_wide = !is_io && (in_q.bar_low[2:1] == pbwa_pkg::MEM_TYPE_64);
    if (is_io) begin
      base  = {32'd0, in_q.bar_low & pbwa_pkg::IO_ADDR_MASK};
      smask = {32'd0, in_q.mask_low & pbwa_pkg::IO_ADDR_MASK} | pbwa_pkg::UPPER_ONES;
    end else if (is_wide) begin
      base  = {in_q.bar_high, in_q.bar_low & pbwa_pkg::MEM_ADDR_MASK};
      smask = {in_q.mask_high, in_q.mask_low & pbwa_pkg::MEM_ADDR_MASK};
    end else begin
      base  = {32'd0, in_q.bar_low & pbwa_pkg::MEM_ADDR_MASK};
      smask = {32'd0, in_q.mask_low & pbwa_pkg::MEM_ADDR_MASK} | pbwa_pkg::UPPER_ONES;
    end
    len = 64'd0 - smask;
    // Length minus one is the inverted size mask, so the carry flags an end
    // address past the top of the 64-bit space.
    last_sum = {1'b0, base} + {1'b0, ~smask};
    range_ok = (base != 64'd0) && (smask != 64'd0) && !last_sum[64];
    if (is_io) begin
      sel = pbwa_pkg::REGION_IO;
    end else if (base[63:32] != 32'd0) begin
      sel = pbwa_pkg::REGION_MEM_HI;
    end else begin
      sel = pbwa_pkg::REGION_MEM_LOW;
    end

    io_win_d = io_win_q;
    lm_win_d = lm_win_q;
    hm_win_d = hm_win_q;
    out_d = '0;
    if (in_q.kind == pbwa_pkg::KIND_CLEAR) begin
      io_win_d = pbwa_pkg::EMPTY_WIN;
      lm_win_d = pbwa_pkg::EMPTY_WIN;
      hm_win_d = pbwa_pkg::EMPTY_WIN;
    end else begin
      out_d.bar_base       = base;
      out_d.bar_length     = len;
      out_d.uses_next_slot = is_wide;
      if (range_ok) begin
        out_d.region = sel;
        case (sel)
          pbwa_pkg::REGION_IO:      io_win_d = widen_win(io_win_q, base, last_sum[63:0]);
          pbwa_pkg::REGION_MEM_LOW: lm_win_d = widen_win(lm_win_q, base, last_sum[63:0]);
          default:                  hm_win_d = widen_win(hm_win_q, base, last_sum[63:0]);
        endcase
      end
    end
    out_d.io_window_base        = io_win_d.lo;
    out_d.io_window_limit       = io_win_d.hi;
    out_d.low_mem_window_base   = lm_win_d.lo;
    out_d.low_mem_window_limit  = lm_win_d.hi;
    out_d.high_mem_window_base  = hm_win_d.lo;
    out_d.high_mem_window_limit = hm_win_d.hi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      io_win_q    <= pbwa_pkg::EMPTY_WIN;
      lm_win_q    <= pbwa_pkg::EMPTY_WIN;
      hm_win_q    <= pbwa_pkg::EMPTY_WIN;
    end else begin
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          io_win_q <= io_win_d;
          lm_win_q <= lm_win_d;
          hm_win_q <= hm_win_d;
        end
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A window is either empty in its canonical form or ordered.
  a_io_win_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (io_win_q.lo <= io_win_q.hi) ||
    (io_win_q.lo == pbwa_pkg::EMPTY_BASE && io_win_q.hi == pbwa_pkg::EMPTY_LIMIT))
    else $error("I/O window is neither empty nor ordered");

  a_hm_win_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hm_win_q.lo <= hm_win_q.hi) ||
    (hm_win_q.lo == pbwa_pkg::EMPTY_BASE && hm_win_q.hi == pbwa_pkg::EMPTY_LIMIT))
    else $error("high memory window is neither empty nor ordered");

  a_included_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.region != pbwa_pkg::REGION_NONE) |->
    (out_data_o.bar_base != 64'd0) && (out_data_o.bar_length != 64'd0))
    else $error("included BAR has zero base or length");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a held item");

endmodule

`default_nettype wire

// ===== bench/pbwa_checker.sv =====
module pbwa_checker
  import pbwa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          checked_o,
  output int          io_hits_o,
  output int          low_hits_o,
  output int          high_hits_o,
  output int          left_out_o,
  output int          clears_o
);

  localparam logic [63:0] FOUR_GIB = 64'h1_0000_0000;

  win_t io_win;
  win_t mem_low_win;
  win_t mem_high_win;
  out_t bar_reports_q[$];
  out_t want;
  int   mismatches;
  int   checked;
  int   io_hits;
  int   low_hits;
  int   high_hits;
  int   left_out;
  int   clears;

  // Merges [base, base + len - 1] into the window; a zero length or an end
  // past the top of the 64-bit space leaves the window as it was.
  function automatic logic fold_range(inout win_t w, input logic [63:0] base,
                                      input logic [63:0] len);
    logic [64:0] end_sum;
    end_sum = {1'b0, base} + {1'b0, len} - 65'd1;
    if (len == 64'd0 || end_sum[64]) return 1'b0;
    if (w.lo > w.hi) begin
      w.lo = base;
      w.hi = end_sum[63:0];
    end else begin
      if (base < w.lo) w.lo = base;
      if (end_sum[63:0] > w.hi) w.hi = end_sum[63:0];
    end
    return 1'b1;
  endfunction

  function automatic out_t predict_report(input in_t it);
    out_t        r;
    logic        is_io;
    logic        is_wide;
    logic        merged;
    logic [1:0]  sel;
    logic [63:0] base;
    logic [63:0] span_mask;
    logic [63:0] len;
    r = '0;
    is_wide = 1'b0;
    merged = 1'b0;
    sel = REGION_NONE;
    base = '0;
    len = '0;
    if (it.kind == KIND_CLEAR) begin
      io_win = EMPTY_WIN;
      mem_low_win = EMPTY_WIN;
      mem_high_win = EMPTY_WIN;
      clears++;
    end else begin
      is_io = it.bar_low[0];
      is_wide = !is_io && (it.bar_low[2:1] == MEM_TYPE_64);
      if (is_io) begin
        base = {32'd0, it.bar_low & IO_ADDR_MASK};
        span_mask = UPPER_ONES | {32'd0, it.mask_low & IO_ADDR_MASK};
      end else if (is_wide) begin
        base = {it.bar_high, it.bar_low & MEM_ADDR_MASK};
        span_mask = {it.mask_high, it.mask_low & MEM_ADDR_MASK};
      end else begin
        base = {32'd0, it.bar_low & MEM_ADDR_MASK};
        span_mask = UPPER_ONES | {32'd0, it.mask_low & MEM_ADDR_MASK};
      end
      len = 64'd0 - span_mask;
      if (base != 64'd0 && len != 64'd0) begin
        if (is_io) begin
          sel = REGION_IO;
          merged = fold_range(io_win, base, len);
        end else if (base >= FOUR_GIB) begin
          sel = REGION_MEM_HI;
          merged = fold_range(mem_high_win, base, len);
        end else begin
          sel = REGION_MEM_LOW;
          merged = fold_range(mem_low_win, base, len);
        end
      end
      if (!merged) sel = REGION_NONE;
      case (sel)
        REGION_IO:      io_hits++;
        REGION_MEM_LOW: low_hits++;
        REGION_MEM_HI:  high_hits++;
        default:        left_out++;
      endcase
    end
    r.bar_base = base;
    r.bar_length = len;
    r.region = sel;
    r.uses_next_slot = is_wide;
    r.io_window_base = io_win.lo;
    r.io_window_limit = io_win.hi;
    r.low_mem_window_base = mem_low_win.lo;
    r.low_mem_window_limit = mem_low_win.hi;
    r.high_mem_window_base = mem_high_win.lo;
    r.high_mem_window_limit = mem_high_win.hi;
    return r;
  endfunction

  function automatic void compare_field(input string fname, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      io_win = EMPTY_WIN;
      mem_low_win = EMPTY_WIN;
      mem_high_win = EMPTY_WIN;
      bar_reports_q.delete();
      mismatches = 0;
      checked = 0;
      io_hits = 0;
      low_hits = 0;
      high_hits = 0;
      left_out = 0;
      clears = 0;
    end else begin
      if (in_valid_i && !in_stall_i) bar_reports_q.push_back(predict_report(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (bar_reports_q.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected, actual %h",
                   $time, out_data_i);
        end else begin
          want = bar_reports_q.pop_front();
          checked++;
          compare_field("bar_base", want.bar_base, out_data_i.bar_base);
          compare_field("bar_length", want.bar_length, out_data_i.bar_length);
          compare_field("region", 64'(want.region), 64'(out_data_i.region));
          compare_field("uses_next_slot", 64'(want.uses_next_slot),
                        64'(out_data_i.uses_next_slot));
          compare_field("io_window_base", want.io_window_base,
                        out_data_i.io_window_base);
          compare_field("io_window_limit", want.io_window_limit,
                        out_data_i.io_window_limit);
          compare_field("low_mem_window_base", want.low_mem_window_base,
                        out_data_i.low_mem_window_base);
          compare_field("low_mem_window_limit", want.low_mem_window_limit,
                        out_data_i.low_mem_window_limit);
          compare_field("high_mem_window_base", want.high_mem_window_base,
                        out_data_i.high_mem_window_base);
          compare_field("high_mem_window_limit", want.high_mem_window_limit,
                        out_data_i.high_mem_window_limit);
        end
      end
    end
    // Published with nonblocking updates so the top reads settled values.
    mismatches_o <= mismatches;
    pending_o <= bar_reports_q.size();
    checked_o <= checked;
    io_hits_o <= io_hits;
    low_hits_o <= low_hits;
    high_hits_o <= high_hits;
    left_out_o <= left_out;
    clears_o <= clears;
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  import pbwa_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t  in_data = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int mismatches;
  int pending;
  int checked;
  int io_hits;
  int low_hits;
  int high_hits;
  int left_out;
  int clears;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pci_bar_window_accumulator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  pbwa_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .io_hits_o    (io_hits),
    .low_hits_o   (low_hits),
    .high_hits_o  (high_hits),
    .left_out_o   (left_out),
    .clears_o     (clears)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  function automatic in_t make_bar(input logic [31:0] bl, input logic [31:0] bh,
                                   input logic [31:0] ml, input logic [31:0] mh);
    return '{kind: 1'b1, bar_low: bl, bar_high: bh, mask_low: ml, mask_high: mh};
  endfunction

  // Mostly well-formed sized BARs of each type, with clears, unaligned bases,
  // zero sizes and fully random words mixed in.
  function automatic in_t random_bar();
    in_t         it;
    int          pick;
    int          k;
    logic [63:0] size;
    logic [63:0] addr;
    logic [63:0] msk;
    logic [3:0]  low_bits;
    it = make_bar($urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(99);
    if (pick < 6) begin
      it.kind = KIND_CLEAR;
    end else if (pick < 16) begin
      it.kind = 1'($urandom_range(1));
    end else if (pick < 38) begin
      k = $urandom_range(2, 16);
      size = 64'd1 << k;
      addr = {$urandom, $urandom} & ~(size - 64'd1);
      if ($urandom_range(15) == 0) addr = '0;
      it.bar_low = addr[31:0] | 32'd1 | (32'($urandom_range(1)) << 1);
      msk = ~(size - 64'd1);
      it.mask_low = msk[31:0] | 32'd1;
    end else if (pick < 66) begin
      k = $urandom_range(4, 31);
      size = 64'd1 << k;
      addr = {32'd0, $urandom} & ~(size - 64'd1);
      if ($urandom_range(15) == 0) addr = '0;
      // Type 00, or one of the reserved types 01 and 11.
      low_bits = {1'($urandom_range(1)), ($urandom_range(2) == 0) ? 2'b00 :
                  (($urandom_range(1) == 0) ? 2'b01 : 2'b11), 1'b0};
      it.bar_low = addr[31:0] | 32'(low_bits);
      msk = ~(size - 64'd1);
      it.mask_low = msk[31:0] | 32'(low_bits);
    end else begin
      k = ($urandom_range(3) == 0) ? $urandom_range(4, 63) : $urandom_range(4, 24);
      size = 64'd1 << k;
      case ($urandom_range(3))
        0:       addr = {32'd0, $urandom};
        3:       addr = {$urandom, $urandom} | 64'hffff_0000_0000_0000;
        default: addr = {$urandom, $urandom};
      endcase
      if ($urandom_range(9) != 0) addr = addr & ~(size - 64'd1);
      msk = ~(size - 64'd1);
      if ($urandom_range(15) == 0) msk = '0;
      low_bits = {1'($urandom_range(1)), MEM_TYPE_64, 1'b0};
      it.bar_low = addr[31:0] & MEM_ADDR_MASK | 32'(low_bits);
      it.bar_high = addr[63:32];
      it.mask_low = msk[31:0] | 32'(low_bits);
      it.mask_high = msk[63:32];
    end
    return it;
  endfunction

  task automatic send_item(input in_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    src_idle_pct = 21;
    sink_stall_pct = 88;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item('{KIND_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0});
    send_item(make_bar(32'h0000_1001, 32'h0, 32'hffff_ff01, 32'h0));
    send_item(make_bar(32'hffff_fffd, 32'hffff_ffff, 32'hffff_fffd, 32'hffff_ffff));
    send_item(make_bar(32'h0000_2001, 32'h0, 32'h0000_0000, 32'h0));
    send_item(make_bar(32'h8000_0000, 32'h0, 32'hf000_0000, 32'h0));
    send_item(make_bar(32'h0010_0002, 32'h0, 32'hfff0_0002, 32'h0));
    send_item(make_bar(32'h0020_000e, 32'h0, 32'hffff_000e, 32'h0));
    send_item(make_bar(32'hc000_000c, 32'h0, 32'hfff0_000c, 32'hffff_ffff));
    send_item(make_bar(32'h0000_0004, 32'h0000_0010, 32'h0000_0004, 32'hffff_ffff));
    send_item(make_bar(32'h0000_0004, 32'h8000_0000, 32'h0000_0004, 32'h8000_0000));
    send_item(make_bar(32'hffff_fff4, 32'hffff_ffff, 32'hffff_ff04, 32'hffff_ffff));
    send_item(make_bar(32'h0000_0000, 32'h0, 32'hffff_0000, 32'h0));
    send_item(make_bar(32'h1000_0004, 32'h0000_0002, 32'h0000_0004, 32'h0000_0000));
    send_item(make_bar(32'h0, 32'h0, 32'h0, 32'h0));
    send_item(make_bar(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    send_item('{KIND_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    send_item(make_bar(32'h4000_0004, 32'h0000_0020, 32'hffff_f00c, 32'hffff_ffff));
    send_item(make_bar(32'h0000_000c, 32'h0000_0010, 32'hffff_f00c, 32'hffff_ffff));
    send_item(make_bar(32'h0000_0000, 32'h0000_0040, 32'hffff_f004, 32'hffff_ffff));
    send_item(make_bar(32'h0800_0008, 32'h0, 32'hfff0_0008, 32'h0));
    send_item(make_bar(32'h0000_0101, 32'h0, 32'hffff_fff1, 32'h0));

    repeat (250) send_item(random_bar());
    src_idle_pct = 88;
    sink_stall_pct = 21;
    repeat (250) send_item(random_bar());
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (250) send_item(random_bar());
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("tb: %0d reports checked over %0d clear items and %0d sized BARs",
             checked, clears, checked - clears);
    $display("tb: folded into io %0d, low mem %0d, high mem %0d; left out %0d",
             io_hits, low_hits, high_hits, left_out);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: timeout with %0d reports outstanding", pending);
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
design/pbwa_pkg.sv
design/pci_bar_window_accumulator.sv
bench/pbwa_checker.sv
bench/tb.sv
